// ===== rtl/srtf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package srtf_pkg;

    localparam int NUM_SLOTS_DEF = 8;
    localparam int TIME_BITS_DEF = 16;

    // fixed field widths on the stream ports
    localparam int SLOT_FW  = 3;
    localparam int TIME_FW  = 16;
    localparam int CMD_W    = 2;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;
    localparam int M_USED_W = SLOT_FW + 3 + 2 * TIME_FW;
    localparam int M_PAD_W  = M_DATA_W - M_USED_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/srtf_tick_scheduler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// load and clear requests: after acceptance the result goes through S_OUT into the output register
// tick requests: after acceptance the result goes through S_SCAN, S_WRITE and S_OUT, with the
// one-slot-per-cycle scan of the slot memories through the shared compare unit
// one request in flight at a time; the next is taken while a result waits in the output register
// reset (rst_n low, asynchronous) clears the clock, the busy bits and the handshake state

module srtf_tick_scheduler
    import srtf_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // slot[2:0], arrival_time[18:3], burst_time[34:19], zero fill
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // cmd[1:0]
    input  wire logic [CMD_W-1:0]    s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // scheduled_slot[2:0], idle[3], completed[4], completion_time[20:5],
    // all_done[21], current_time[37:22], zero fill
    output logic [M_DATA_W-1:0]      m_tdata
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam logic [CNT_W-1:0]     CNT_LAST = CNT_W'(NUM_SLOTS);
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_WRITE = 4'b0100,
        S_OUT   = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  cmp_valid_reg, cmp_valid_next;
    logic [SLOT_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic                  pick_valid_reg, pick_valid_next;
    logic [SLOT_W-1:0]     pick_idx_reg, pick_idx_next;
    logic [TIME_BITS-1:0]  pick_rem_reg, pick_rem_next;
    logic [TIME_BITS-1:0]  pick_arr_reg, pick_arr_next;
    logic [TIME_BITS-1:0]  clk_reg, clk_next;
    logic [NUM_SLOTS-1:0]  busy_reg, busy_next;
    logic [SLOT_W-1:0]     res_slot_reg, res_slot_next;
    logic                  res_idle_reg, res_idle_next;
    logic                  res_done_reg, res_done_next;
    logic [TIME_BITS-1:0]  res_ctime_reg, res_ctime_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]   m_tdata_reg, m_tdata_next;

    // slot memories
    logic [TIME_BITS-1:0]  arr_mem [NUM_SLOTS];
    logic [TIME_BITS-1:0]  rem_mem [NUM_SLOTS];
    logic [TIME_BITS-1:0]  rd_arr_reg;
    logic [TIME_BITS-1:0]  rd_rem_reg;
    logic [SLOT_W-1:0]     rd_addr;
    logic                  arr_we;
    logic                  rem_we;
    logic [SLOT_W-1:0]     rem_waddr;
    logic [TIME_BITS-1:0]  rem_wdata;

    // request unpacking
    cmd_t                          in_cmd;
    logic [SLOT_FW-1:0]            in_slot;
    logic [TIME_FW-1:0]            in_arr;
    logic [TIME_FW-1:0]            in_bur;
    logic [SLOT_W+SLOT_FW-1:0]     slot_ext;
    logic [SLOT_W-1:0]             slot_idx;
    logic                          slot_ok;
    logic [TIME_BITS+TIME_FW-1:0]  arr_ext;
    logic [TIME_BITS+TIME_FW-1:0]  bur_ext;
    logic [TIME_BITS-1:0]          arr_t;
    logic [TIME_BITS-1:0]          bur_t;

    // shared compare unit and tick arithmetic
    logic                  eligible;
    logic                  better;
    logic [TIME_BITS-1:0]  clk_inc;
    logic [TIME_BITS-1:0]  rem_dec;

    // result packing
    logic [SLOT_W+SLOT_FW-1:0]     res_slot_ext;
    logic [TIME_BITS+TIME_FW-1:0]  ctime_ext;
    logic [TIME_BITS+TIME_FW-1:0]  cur_ext;
    logic                          all_done;

    assign in_cmd   = cmd_t'(s_tuser);
    assign in_slot  = s_tdata[SLOT_FW-1:0];
    assign in_arr   = s_tdata[SLOT_FW +: TIME_FW];
    assign in_bur   = s_tdata[SLOT_FW + TIME_FW +: TIME_FW];
    assign slot_ext = {{SLOT_W{1'b0}}, in_slot};
    assign slot_idx = slot_ext[SLOT_W-1:0];
    assign slot_ok  = slot_ext < (SLOT_W + SLOT_FW)'(NUM_SLOTS);
    assign arr_ext  = {{TIME_BITS{1'b0}}, in_arr};
    assign bur_ext  = {{TIME_BITS{1'b0}}, in_bur};
    assign arr_t    = arr_ext[TIME_BITS-1:0];
    assign bur_t    = bur_ext[TIME_BITS-1:0];

    assign rd_addr  = (cnt_reg != CNT_LAST) ? cnt_reg[SLOT_W-1:0] : '0;

    assign eligible = busy_reg[cmp_idx_reg] && (rd_arr_reg <= clk_reg);
    assign better   = !pick_valid_reg || (rd_rem_reg < pick_rem_reg) ||
                      ((rd_rem_reg == pick_rem_reg) && (rd_arr_reg < pick_arr_reg));
    assign clk_inc  = (clk_reg == TIME_MAX) ? clk_reg : clk_reg + 1'b1;
    assign rem_dec  = pick_rem_reg - 1'b1;

    assign res_slot_ext = {{SLOT_FW{1'b0}}, res_slot_reg};
    assign ctime_ext    = {{TIME_FW{1'b0}}, res_ctime_reg};
    assign cur_ext      = {{TIME_FW{1'b0}}, clk_reg};
    assign all_done     = ~|busy_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        cmp_valid_next  = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        pick_valid_next = pick_valid_reg;
        pick_idx_next   = pick_idx_reg;
        pick_rem_next   = pick_rem_reg;
        pick_arr_next   = pick_arr_reg;
        clk_next        = clk_reg;
        busy_next       = busy_reg;
        res_slot_next   = res_slot_reg;
        res_idle_next   = res_idle_reg;
        res_done_next   = res_done_reg;
        res_ctime_next  = res_ctime_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        arr_we          = 1'b0;
        rem_we          = 1'b0;
        rem_waddr       = slot_idx;
        rem_wdata       = bur_t;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    res_slot_next  = '0;
                    res_idle_next  = 1'b0;
                    res_done_next  = 1'b0;
                    res_ctime_next = '0;
                    state_next     = S_OUT;
                    unique case (in_cmd)
                        CMD_LOAD:
                        begin
                            if (slot_ok)
                            begin
                                arr_we              = 1'b1;
                                rem_we              = 1'b1;
                                busy_next[slot_idx] = |bur_t;
                            end
                        end
                        CMD_TICK:
                        begin
                            cnt_next        = '0;
                            pick_valid_next = 1'b0;
                            state_next      = S_SCAN;
                        end
                        CMD_CLEAR:
                        begin
                            busy_next = '0;
                            clk_next  = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // read one slot per cycle, compare the previous read
                if (cnt_reg != CNT_LAST)
                begin
                    cnt_next       = cnt_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = rd_addr;
                end
                else
                begin
                    state_next = S_WRITE;
                end
                if (cmp_valid_reg && eligible && better)
                begin
                    pick_valid_next = 1'b1;
                    pick_idx_next   = cmp_idx_reg;
                    pick_rem_next   = rd_rem_reg;
                    pick_arr_next   = rd_arr_reg;
                end
            end
            S_WRITE:
            begin
                clk_next   = clk_inc;
                state_next = S_OUT;
                if (pick_valid_reg)
                begin
                    rem_we        = 1'b1;
                    rem_waddr     = pick_idx_reg;
                    rem_wdata     = rem_dec;
                    res_slot_next = pick_idx_reg;
                    if (rem_dec == '0)
                    begin
                        busy_next[pick_idx_reg] = 1'b0;
                        res_done_next           = 1'b1;
                        res_ctime_next          = clk_inc;
                    end
                end
                else
                begin
                    res_idle_next = 1'b1;
                end
            end
            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{M_PAD_W{1'b0}},
                                     cur_ext[TIME_FW-1:0],
                                     all_done,
                                     ctime_ext[TIME_FW-1:0],
                                     res_done_reg,
                                     res_idle_reg,
                                     res_slot_ext[SLOT_FW-1:0]};
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            cmp_valid_reg  <= 1'b0;
            pick_valid_reg <= 1'b0;
            clk_reg        <= '0;
            busy_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            cmp_valid_reg  <= cmp_valid_next;
            pick_valid_reg <= pick_valid_next;
            clk_reg        <= clk_next;
            busy_reg       <= busy_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg   <= cmp_idx_next;
        pick_idx_reg  <= pick_idx_next;
        pick_rem_reg  <= pick_rem_next;
        pick_arr_reg  <= pick_arr_next;
        res_slot_reg  <= res_slot_next;
        res_idle_reg  <= res_idle_next;
        res_done_reg  <= res_done_next;
        res_ctime_reg <= res_ctime_next;
        m_tdata_reg   <= m_tdata_next;
    end

    // slot memories, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (arr_we)
        begin
            arr_mem[slot_idx] <= arr_t;
        end
        if (rem_we)
        begin
            rem_mem[rem_waddr] <= rem_wdata;
        end
        rd_arr_reg <= arr_mem[rd_addr];
        rd_rem_reg <= rem_mem[rd_addr];
    end

    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (in_cmd == CMD_CLEAR) |=> (clk_reg == '0) && (busy_reg == '0))
        else $error("clear request did not zero clock and remaining work");

    a_pick_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) && pick_valid_reg |-> (pick_rem_reg != '0) && busy_reg[pick_idx_reg])
        else $error("picked slot has no remaining work");

    a_tick_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |=> (clk_reg != '0) && (state_reg == S_OUT))
        else $error("tick did not advance the clock");

endmodule

`default_nettype wire
